// ===== rtl/primitive_batch_split_carryover_unit_macros.svh =====
// Assertion macros shared by the primitive batch split RTL.
// Included by the files that check their own logic; needs a clk and rst in scope.
`ifndef PRIMITIVE_BATCH_SPLIT_CARRYOVER_UNIT_MACROS_SVH
`define PRIMITIVE_BATCH_SPLIT_CARRYOVER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Condition that must hold at every clock edge outside reset.
`define PBSC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies a sequence, checked outside reset.
`define PBSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);
`else
`define PBSC_ASSERT(label, cond, msg)
`define PBSC_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

// ===== rtl/pbsc_pkg.sv =====
// Package for the primitive batch split unit: beat types, mode codes and constants.
// Depends on nothing; used by pbsc_calc and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pbsc_pkg;

  // Vertex buffer depth; the fill is saturated to this value.
  localparam logic [6:0] BUFFER_DEPTH = 7'd64;

  localparam logic [3:0] MODE_POINTS      = 4'd0;
  localparam logic [3:0] MODE_LINES       = 4'd1;
  localparam logic [3:0] MODE_LINE_LOOP   = 4'd2;
  localparam logic [3:0] MODE_LINE_STRIP  = 4'd3;
  localparam logic [3:0] MODE_TRIS        = 4'd4;
  localparam logic [3:0] MODE_TRI_STRIP   = 4'd5;
  localparam logic [3:0] MODE_TRI_FAN     = 4'd6;
  localparam logic [3:0] MODE_POLYGON     = 4'd7;
  localparam logic [3:0] MODE_QUADS       = 4'd8;
  localparam logic [3:0] MODE_QUAD_STRIP  = 4'd9;

  // Reciprocal of three scaled by 128, exact for seven-bit counts.
  localparam logic [12:0] RECIP3 = 13'd43;

  typedef struct packed {
    logic [3:0]        prim_mode;
    logic signed [7:0] prim_count_raw;
    logic              prim_ended;
    logic [5:0]        first_vertex;
    logic [6:0]        buffer_vertices;
  } item_t;

  typedef struct packed {
    logic [6:0] kept_count;
    logic [6:0] draw_length;
    logic [1:0] carry_count;
    logic [5:0] carry_src0;
    logic [5:0] carry_src1;
    logic [5:0] carry_src2;
    logic       parity_toggle;
    logic       continues;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/pbsc_calc.sv =====
// Combinational flush decision for one beat: count correction, trim and carry-over.
// Depends on pbsc_pkg for the beat types and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module pbsc_calc (
  input  pbsc_pkg::item_t   item,
  output pbsc_pkg::result_t result
);

  logic [6:0]        num;
  logic [6:0]        add;
  logic signed [8:0] corr;
  logic [6:0]        cnt;
  logic [12:0]       prod;
  logic [5:0]        quo;
  logic [6:0]        rem7;
  logic [1:0]        rem;
  logic [1:0]        trim;
  logic [1:0]        copy;
  logic              fan_like;
  logic [5:0]        base;

  always_comb begin
    num = (item.buffer_vertices > pbsc_pkg::BUFFER_DEPTH) ? pbsc_pkg::BUFFER_DEPTH
                                                          : item.buffer_vertices;
    add = item.prim_ended ? 7'd0 : num;
    corr = $signed({item.prim_count_raw[7], item.prim_count_raw}) + $signed({2'b00, add});
    if (corr[8]) begin
      cnt = 7'd0;
    end else if (corr[7]) begin
      cnt = 7'd127;
    end else begin
      cnt = corr[6:0];
    end

    // Remainder by three via the scaled reciprocal and one back-multiply.
    prod = 13'(cnt) * pbsc_pkg::RECIP3;
    quo  = prod[12:7];
    rem7 = cnt - 7'({1'b0, quo} * 7'd3);
    rem  = rem7[1:0];

    unique case (item.prim_mode)
      pbsc_pkg::MODE_LINES:      trim = {1'b0, cnt[0]};
      pbsc_pkg::MODE_LINE_LOOP,
      pbsc_pkg::MODE_LINE_STRIP: trim = (cnt < 7'd2) ? cnt[1:0] : 2'd0;
      pbsc_pkg::MODE_TRIS:       trim = rem;
      pbsc_pkg::MODE_TRI_STRIP,
      pbsc_pkg::MODE_TRI_FAN,
      pbsc_pkg::MODE_POLYGON:    trim = (cnt < 7'd3) ? cnt[1:0] : 2'd0;
      pbsc_pkg::MODE_QUADS:      trim = cnt[1:0];
      pbsc_pkg::MODE_QUAD_STRIP: trim = (cnt < 7'd4) ? cnt[1:0] : {1'b0, cnt[0]};
      default:                   trim = 2'd0;
    endcase

    fan_like = 1'b0;
    copy     = 2'd0;
    if (!item.prim_ended) begin
      unique case (item.prim_mode)
        pbsc_pkg::MODE_LINES:      copy = {1'b0, cnt[0]};
        pbsc_pkg::MODE_LINE_LOOP,
        pbsc_pkg::MODE_TRI_FAN,
        pbsc_pkg::MODE_POLYGON: begin
          fan_like = 1'b1;
          copy     = (cnt >= 7'd2) ? 2'd2 : cnt[1:0];
        end
        pbsc_pkg::MODE_LINE_STRIP: copy = (cnt != 7'd0) ? 2'd1 : 2'd0;
        pbsc_pkg::MODE_TRIS:       copy = rem;
        pbsc_pkg::MODE_TRI_STRIP:  copy = (cnt < 7'd2) ? cnt[1:0] : 2'd2;
        pbsc_pkg::MODE_QUADS:      copy = cnt[1:0];
        pbsc_pkg::MODE_QUAD_STRIP: copy = (cnt < 7'd2) ? cnt[1:0] : 2'd2 + {1'b0, cnt[0]};
        default:                   copy = 2'd0;
      endcase
    end

    // Carried vertices are the last ones in the buffer, indices wrap at the depth.
    base = num[5:0] - {4'b0000, copy};

    result.kept_count  = cnt - {5'b00000, trim};
    result.draw_length = ({5'b00000, trim} > num) ? 7'd0 : num - {5'b00000, trim};
    result.carry_count = copy;
    if (fan_like) begin
      // Fan-like primitives keep their first vertex and the latest one.
      result.carry_src0 = (copy >= 2'd1) ? item.first_vertex : 6'd0;
      result.carry_src1 = (copy >= 2'd2) ? num[5:0] - 6'd1 : 6'd0;
      result.carry_src2 = 6'd0;
    end else begin
      result.carry_src0 = (copy >= 2'd1) ? base : 6'd0;
      result.carry_src1 = (copy >= 2'd2) ? base + 6'd1 : 6'd0;
      result.carry_src2 = (copy == 2'd3) ? base + 6'd2 : 6'd0;
    end
    result.parity_toggle = !item.prim_ended && (cnt > 7'd1) && cnt[0];
    result.continues     = !item.prim_ended;
  end

endmodule

`default_nettype wire

// ===== rtl/primitive_batch_split_carryover_unit.sv =====
// Top level of the primitive batch split unit: input and result registers around pbsc_calc.
// Depends on pbsc_pkg, pbsc_calc and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "primitive_batch_split_carryover_unit_macros.svh"

// One beat is accepted in every cycle that start is high; busy never rises.
// Each beat gives exactly one result, shown on result with done high for a
// single cycle, once the beat has passed through the input register and then
// through the trim and carry logic into the result register.
// The receiver must take the result in that cycle, as nothing holds it.
// Results leave in the order in which beats were accepted.
module primitive_batch_split_carryover_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pbsc_pkg::item_t   item,
  output logic              done,
  output pbsc_pkg::result_t result
);

  logic              in_valid;
  pbsc_pkg::item_t   in_q;
  pbsc_pkg::result_t calc_out;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_q <= item;
    end
    if (in_valid) begin
      result <= calc_out;
    end
  end

  pbsc_calc u_calc (
    .item   (in_q),
    .result (calc_out)
  );

  `PBSC_ASSERT_IMPL(a_done_latency, start, ##2 done, "accepted beat did not give a result")
  `PBSC_ASSERT_IMPL(a_ended_no_carry, done && !result.continues,
    (result.carry_count == 2'd0 && result.parity_toggle == 1'b0), "ended primitive carries")
  `PBSC_ASSERT_IMPL(a_free_slot_zero, done && result.carry_count != 2'd3,
    (result.carry_src2 == 6'd0), "unused carry slot not cleared")
  `PBSC_ASSERT_IMPL(a_draw_in_depth, done,
    (result.draw_length <= pbsc_pkg::BUFFER_DEPTH), "draw length beyond buffer depth")

endmodule

`default_nettype wire
